>>> sv/bbo_pkg.sv
// Package for the bucketed bit offset allocator: item types, codes and sizing constants.
// No dependencies; used by the top level, the checker and the bench.
`default_nettype none

package bbo_pkg;

  localparam int SIZE_BITS    = 16;
  localparam int BUCKET_COUNT = 6;
  localparam int BKT_W        = 3;   // bucket index bits
  localparam int SLOT_W       = 7;   // slot counter bits (up to 64 slots)
  localparam int WORD_BITS    = 64;
  localparam int LARGE_ROUND  = 63;
  localparam int SMALL_LIMIT  = 32;
  localparam int OUT_BITS     = 32;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [SIZE_BITS-1:0] request_size;
  } req_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] bit_offset;
    logic                space_full;
  } rsp_t;

  // Smallest power-of-two bucket that holds the size; capped at the last bucket.
  function automatic logic [BKT_W-1:0] bucket_of(input logic [SIZE_BITS-1:0] size);
    logic [BKT_W-1:0] b;
    if (size <= SIZE_BITS'(1)) b = BKT_W'(0);
    else if (size <= SIZE_BITS'(2)) b = BKT_W'(1);
    else if (size <= SIZE_BITS'(4)) b = BKT_W'(2);
    else if (size <= SIZE_BITS'(8)) b = BKT_W'(3);
    else if (size <= SIZE_BITS'(16)) b = BKT_W'(4);
    else b = BKT_W'(BUCKET_COUNT - 1);
    return b;
  endfunction

endpackage

`default_nettype wire

>>> sv/bucketed_bit_offset_allocator.sv
// Top level of the bucketed bit offset allocator: control, bucket RAM and space pointer.
// Depends on bbo_pkg and bbo_ram.
//
//   channel | valid     | stall     | payload           | dir
//   --------+-----------+-----------+-------------------+-----
//   request | req_valid | req_stall | req (kind, size)  | in
//   result  | rsp_valid | rsp_stall | rsp (offset,full) | out
//
// An item passes through ST_IDLE and ST_CALC: the accept edge reads the bucket entry
// from the bucket RAM (registered read data); the step edge in ST_CALC then updates
// the entry and loads the result. One item is in flight at a time.
// A result held by rsp_stall does not block the next accept; the update step waits
// only while the output register is still full and stalled.
// rst (synchronous) empties all buckets and the space; no clearing pass is needed.
`default_nettype none

module bucketed_bit_offset_allocator #(
  parameter int OFFSET_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  bbo_pkg::req_t req,
  input  logic          req_valid,
  output logic          req_stall,
  output bbo_pkg::rsp_t rsp,
  output logic          rsp_valid,
  input  logic          rsp_stall
);

  import bbo_pkg::*;

  // RAM entry: {next offset, slots left}
  localparam int EW = OFFSET_BITS + SLOT_W;
  // wide enough for space pointer plus any rounded large request, with a carry bit
  localparam int AW = ((OFFSET_BITS > SIZE_BITS + 1) ? OFFSET_BITS : SIZE_BITS + 1) + 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CALC = 2'b10
  } state_t;

  state_t state, state_next;

  logic                    kind_q;
  logic [SIZE_BITS-1:0]    size_q;
  logic [BKT_W-1:0]        bkt_q;
  logic [BUCKET_COUNT-1:0] bkt_valid;   // cleared bucket reads as zero slots
  logic [OFFSET_BITS-1:0]  eos, eos_next;

  logic accept, step;
  logic [EW-1:0] rd_data, wr_data;
  logic          wr_en;

  logic [SLOT_W-1:0]      slots_cur, wr_slots;
  logic [OFFSET_BITS-1:0] off_cur, wr_off, slot_sz, res_off;
  logic                   res_full, flush;
  logic [AW-1:0]          grow64, amount, grow_lg;
  logic                   room64, room_lg;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  // update step happens once the output register can take the result
  assign step      = (state == ST_CALC) && (!rsp_valid || !rsp_stall);

  bbo_ram #(
    .WIDTH (EW),
    .DEPTH (BUCKET_COUNT)
  ) u_bkt_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (bkt_q),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (bucket_of(req.request_size)),
    .rd_data (rd_data)
  );

  // bucket entry as read; a flushed or never-used bucket has no slots
  assign slots_cur = bkt_valid[bkt_q] ? rd_data[SLOT_W-1:0] : '0;
  assign off_cur   = rd_data[EW-1:SLOT_W];
  assign slot_sz   = {{(OFFSET_BITS-1){1'b0}}, 1'b1} << bkt_q;

  // range checks: the grown pointer must stay within OFFSET_BITS
  assign grow64  = AW'(eos) + AW'(WORD_BITS);
  assign room64  = (grow64[AW-1:OFFSET_BITS] == '0);
  assign amount  = (AW'(size_q) + AW'(LARGE_ROUND)) & ~AW'(LARGE_ROUND);
  assign grow_lg = AW'(eos) + amount;
  assign room_lg = (grow_lg[AW-1:OFFSET_BITS] == '0);

  always_comb begin
    res_off  = '0;
    res_full = 1'b0;
    eos_next = eos;
    wr_en    = 1'b0;
    wr_off   = off_cur;
    wr_slots = slots_cur;
    flush    = 1'b0;
    if (kind_q == KIND_FLUSH) begin
      flush = 1'b1;
    end else if (size_q == '0) begin
      // zero size: nothing moves
    end else if (size_q <= SIZE_BITS'(SMALL_LIMIT)) begin
      if (slots_cur == '0) begin
        // bucket empty: claim a fresh word at the end of the space
        if (!room64) begin
          res_full = 1'b1;
        end else begin
          res_off  = eos;
          eos_next = grow64[OFFSET_BITS-1:0];
          wr_off   = eos + slot_sz;
          wr_slots = (SLOT_W'(WORD_BITS) >> bkt_q) - SLOT_W'(1);
          wr_en    = step;
        end
      end else begin
        res_off  = off_cur;
        wr_off   = off_cur + slot_sz;
        wr_slots = slots_cur - SLOT_W'(1);
        wr_en    = step;
      end
    end else begin
      if (!room_lg) begin
        res_full = 1'b1;
      end else begin
        res_off  = eos;
        eos_next = grow_lg[OFFSET_BITS-1:0];
      end
    end
  end

  assign wr_data = {wr_off, wr_slots};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_CALC;
      end
      ST_CALC: begin
        if (step) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      eos       <= '0;
      bkt_valid <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (step) begin
        eos <= eos_next;
        if (flush) begin
          bkt_valid <= '0;
        end else if (wr_en) begin
          bkt_valid[bkt_q] <= 1'b1;
        end
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= req.kind;
      size_q <= req.request_size;
      bkt_q  <= bucket_of(req.request_size);
    end
    if (step) begin
      rsp.bit_offset <= OUT_BITS'(res_off);
      rsp.space_full <= res_full;
    end
  end

endmodule

`default_nettype wire

>>> sv/bbo_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module bbo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> sv/bbo_checker.sv
// Port-level checker for the bucketed bit offset allocator, bound to the top level.
// Depends on bbo_pkg and bucketed_bit_offset_allocator.
`default_nettype none

module bbo_checker (
  input logic          clk,
  input logic          rst,
  input bbo_pkg::req_t req,
  input logic          req_valid,
  input logic          req_stall,
  input bbo_pkg::rsp_t rsp,
  input logic          rsp_valid,
  input logic          rsp_stall
);

  import bbo_pkg::*;

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // a refused request never carries an offset
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.space_full |-> rsp.bit_offset == '0)
    else $error("full result with nonzero offset");

  // one item at a time: the block is busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while previous item in flight");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind bucketed_bit_offset_allocator bbo_checker u_bbo_checker (
  .clk       (clk),
  .rst       (rst),
  .req       (req),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp       (rsp),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall)
);

`default_nettype wire

>>> bench/bucketed_bit_offset_allocator_tb.sv
// Self-checking bench for bucketed_bit_offset_allocator: random and directed requests,
// an in-bench offset predictor, and a scoreboard of expected results.
// Depends on bbo_pkg and the allocator RTL.

module bucketed_bit_offset_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bbo_pkg::*;

  localparam int OFF_W      = 32;    // offset width of the instance under test
  localparam int HOLD_LEN   = 300;   // long receiver hold-off, in cycles
  localparam int DOG_LIMIT  = 2000;  // cycles with no handshake before giving up

  logic clk = 1'b0;
  logic rst;
  req_t req;
  logic req_valid;
  logic req_stall;
  rsp_t rsp;
  logic rsp_valid;
  logic rsp_stall;

  bucketed_bit_offset_allocator #(.OFFSET_BITS(OFF_W)) u_top (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp      (rsp),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: mirrors the allocator's space pointer and bucket table.
  logic [OFF_W-1:0]  space_end;
  logic [OFF_W-1:0]  bucket_off [BUCKET_COUNT];
  logic [SLOT_W-1:0] slots_left [BUCKET_COUNT];

  req_t req_backlog [$];   // requests waiting for the driver
  rsp_t offset_due  [$];   // predicted results, oldest first

  int  n_mismatch = 0;
  int  n_requests = 0;
  int  n_results  = 0;
  int  n_refused  = 0;
  int  n_flush    = 0;
  int  send_gap   = 0;
  int  rx_wait    = 0;
  int  hold_cnt   = 0;
  int  dog_cnt    = 0;
  bit  quiet      = 1'b0;  // no idling on either side while set
  bit  hold_long  = 1'b0;  // asks the receiver for one long hold-off

  // Idle gap before the next item: zero while quiet is set, else often zero, else random.
  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  // Works out the result of one request and advances the predictor state.
  function automatic rsp_t allocate_offset(req_t r);
    rsp_t             res;
    int               b;
    logic [OFF_W-1:0] slot;
    logic [OFF_W-1:0] amount;
    logic [OFF_W:0]   headroom;
    res = '0;
    // bits the space pointer may still grow by without leaving the range
    headroom = {1'b0, {OFF_W{1'b1}}} - {1'b0, space_end};
    if (r.kind == KIND_FLUSH) begin
      for (int i = 0; i < BUCKET_COUNT; i++) slots_left[i] = '0;
    end else if (r.request_size != '0 && r.request_size <= SIZE_BITS'(SMALL_LIMIT)) begin
      b = 0;
      while (b < BUCKET_COUNT - 1 && (OFF_W'(1) << b) < OFF_W'(r.request_size)) b++;
      slot = OFF_W'(1) << b;
      if (slots_left[b] == '0) begin
        // bucket word used up: claim a fresh word at the end of the space
        if (headroom < (OFF_W + 1)'(WORD_BITS)) begin
          res.space_full = 1'b1;
        end else begin
          bucket_off[b] = space_end;
          space_end     = space_end + OFF_W'(WORD_BITS);
          slots_left[b] = SLOT_W'(WORD_BITS >> b);
        end
      end
      if (!res.space_full) begin
        res.bit_offset = bucket_off[b];
        bucket_off[b]  = bucket_off[b] + slot;
        slots_left[b]  = slots_left[b] - 1'b1;
      end
    end else if (r.request_size != '0) begin
      // large request: whole 64-bit words at the end of the space
      amount = (OFF_W'(r.request_size) + OFF_W'(LARGE_ROUND)) & ~OFF_W'(LARGE_ROUND);
      if (headroom < {1'b0, amount}) begin
        res.space_full = 1'b1;
      end else begin
        res.bit_offset = space_end;
        space_end      = space_end + amount;
      end
    end
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [OFF_W-1:0] got, logic [OFF_W-1:0] want);
    n_mismatch++;
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Driver: presents the backlog one item at a time, holding while stalled.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_valid && !req_stall) begin
        rsp_t due;
        due = allocate_offset(req);
        offset_due.push_back(due);
        n_requests++;
        if (req.kind == KIND_FLUSH) n_flush++;
        if (due.space_full) n_refused++;
      end
      if (!req_valid || !req_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          req       <= req_backlog.pop_front();
          req_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes results, checks them against the oldest prediction, drives stall.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      rx_wait  = 0;
      hold_cnt = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_t want;
        n_results++;
        if (offset_due.size() == 0) begin
          flag_mismatch("result with nothing expected", rsp.bit_offset, '0);
        end else begin
          want = offset_due.pop_front();
          if (rsp.bit_offset !== want.bit_offset)
            flag_mismatch("bit_offset", rsp.bit_offset, want.bit_offset);
          if (rsp.space_full !== want.space_full)
            flag_mismatch("space_full", OFF_W'(rsp.space_full), OFF_W'(want.space_full));
        end
        rx_wait = pick_gap();
      end
      if (hold_long) begin
        hold_long = 1'b0;
        hold_cnt  = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any handshake means the block is hung.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      dog_cnt = 0;
    end else begin
      dog_cnt++;
      if (dog_cnt >= DOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", DOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic queue_item(logic k, int sz);
    req_t r;
    r.kind         = k;
    r.request_size = SIZE_BITS'(sz);
    req_backlog.push_back(r);
  endtask

  // Random mix: mostly small and mid-size allocations, some flushes and zero sizes,
  // and a share drawn over the whole size field.
  task automatic queue_random(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)       queue_item(KIND_FLUSH, $urandom_range(0, 65535));
      else if (pick < 10) queue_item(KIND_ALLOC, 0);
      else if (pick < 65) queue_item(KIND_ALLOC, $urandom_range(1, SMALL_LIMIT));
      else if (pick < 88) queue_item(KIND_ALLOC, $urandom_range(SMALL_LIMIT + 1, 1024));
      else                queue_item(KIND_ALLOC, $urandom_range(0, 65535));
    end
  endtask

  // Sender waits here until the block is empty and every result is in.
  task automatic drain();
    while (req_backlog.size() != 0 || req_valid || offset_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    rst       = 1'b1;
    req       = '0;
    req_valid = 1'b0;
    rsp_stall = 1'b0;
    space_end = '0;
    for (int i = 0; i < BUCKET_COUNT; i++) begin
      bucket_off[i] = '0;
      slots_left[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero size, every bucket and its round-up, the smallest and
    // largest large requests, flush with a nonzero size, and bucket rollover.
    queue_item(KIND_ALLOC, 0);
    queue_item(KIND_ALLOC, 1);
    queue_item(KIND_ALLOC, 2);
    queue_item(KIND_ALLOC, 3);
    queue_item(KIND_ALLOC, 5);
    queue_item(KIND_ALLOC, 8);
    queue_item(KIND_ALLOC, 9);
    queue_item(KIND_ALLOC, 16);
    queue_item(KIND_ALLOC, 17);
    queue_item(KIND_ALLOC, 32);
    queue_item(KIND_ALLOC, 32);
    queue_item(KIND_ALLOC, 32);   // takes the second slot of the word claimed by the 32 just above
    queue_item(KIND_ALLOC, 33);
    queue_item(KIND_ALLOC, 64);
    queue_item(KIND_ALLOC, 65);
    queue_item(KIND_ALLOC, 65535);
    queue_item(KIND_ALLOC, 1);
    queue_item(KIND_FLUSH, 65535);
    queue_item(KIND_ALLOC, 1);    // bucket emptied by the flush: fresh word
    queue_item(KIND_ALLOC, 4);
    queue_item(KIND_FLUSH, 0);
    queue_item(KIND_ALLOC, 32768);
    drain();

    // Random traffic, then a long receiver hold-off while the sender keeps going.
    queue_random(600);
    while (req_backlog.size() > 150) @(negedge clk);
    hold_long = 1'b1;
    drain();

    queue_random(700);
    drain();
    // a stretch with no idling on either side
    quiet = 1'b1;
    queue_random(300);
    drain();
    quiet = 1'b0;
    queue_random(350);
    drain();

    // Flushes mixed with small, large and zero-size requests, then a random tail.
    queue_item(KIND_FLUSH, 1);
    queue_item(KIND_ALLOC, 1);
    queue_item(KIND_ALLOC, 32);
    queue_item(KIND_ALLOC, 33);
    queue_item(KIND_ALLOC, 2);
    queue_item(KIND_ALLOC, 1);
    queue_item(KIND_ALLOC, 32);
    queue_item(KIND_ALLOC, 32);
    queue_item(KIND_ALLOC, 64);
    queue_item(KIND_ALLOC, 0);
    queue_item(KIND_ALLOC, 65535);
    queue_item(KIND_ALLOC, 16);
    queue_item(KIND_FLUSH, 0);
    queue_item(KIND_ALLOC, 1);
    queue_random(40);
    drain();

    repeat (8) @(negedge clk);
    if (offset_due.size() != 0)
      flag_mismatch("results never arrived", OFF_W'(offset_due.size()), '0);

    $display("Ran %0d requests (%0d flushes, %0d refused as full), %0d results checked,",
             n_requests, n_flush, n_refused, n_results);
    $display("including a %0d-cycle receiver hold-off and a stretch with no idle cycles.",
             HOLD_LEN);
    if (n_mismatch == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
sv/bbo_pkg.sv
sv/bbo_ram.sv
sv/bucketed_bit_offset_allocator.sv
sv/bbo_checker.sv
bench/bucketed_bit_offset_allocator_tb.sv
